// ----- hdl/manm_pkg.sv -----
// Shared types and constants for the moving average noise metric unit.
package manm_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned LEN_W      = 5;
   localparam int unsigned QUALITY_W  = 9;
   localparam int unsigned WINDOW_MAX = 16;
   localparam logic [LEN_W-1:0] WINDOW_RESET = 5'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV_MEAN,
      ST_VAR,
      ST_DIV_VAR,
      ST_SQRT,
      ST_OUT
   } seq_state_type;

   // Divider handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
   } div_rsp_type;

endpackage

// ----- hdl/manm_if.sv -----
// Valid/ready stream interfaces for request and response channels.
interface manm_req_if;
   import manm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface manm_rsp_if;
   import manm_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  mean;
   logic [QUALITY_W-1:0]        quality;
   modport source (output valid, output mean, output quality, input ready);
   modport sink   (input valid, input mean, input quality, output ready);
endinterface

// ----- hdl/manm_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module manm_div
   import manm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [47:0]      quot_ff, quot_in;
   logic [LEN_W:0]   rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [LEN_W+1:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[47]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[46:0], 1'b0};
         if (trial >= {2'b00, req.divisor}) begin
            rem_in     = LEN_W'(trial - {2'b00, req.divisor}) == 0 ?
                         '0 : (LEN_W+1)'(trial - {2'b00, req.divisor});
            quot_in[0] = 1'b1;
         end else begin
            rem_in = (LEN_W+1)'(trial);
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

// ----- hdl/manm_sqrt.sv -----
// Bit-pair integer square root, one result bit per cycle.
module manm_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        done,
   output logic [15:0] root
);

   logic [31:0] x_ff, x_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         res_in  = '0;
         bit_in  = 32'h4000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= res_ff + bit_ff) begin
            x_in   = x_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 32'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[15:0];

endmodule

// ----- hdl/moving_average_noise_metric_unit.sv -----
// Moving average noise metric unit: window memory, sequencer and output register.
// Sequence per request: sum pass over the n held samples (n = window fill, at most 16),
//   mean division, variance pass, variance division, square root, output; both divisions are 48-bit bit-serial.
// Throughput: one request at a time, taken only while the sequencer is idle; a waiting response
//   holds only the final step, not the request side. Reset: synchronous, active high;
//   clears fill count, write pointer, sequencer and response valid; window_length is 10.
module moving_average_noise_metric_unit
   import manm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [LEN_W-1:0] csr_write_data,
   manm_req_if.sink         req,
   manm_rsp_if.source       rsp
);

   localparam int unsigned PTR_W = $clog2(WINDOW_MAX);
   localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);

   // Window length register
   logic [LEN_W-1:0] win_len_ff;
   logic [CNT_W-1:0] eff_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         win_len_ff <= csr_write_data;
      end
   end

   // zero means one, anything beyond the store depth means the full store
   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (32'(win_len_ff) > WINDOW_MAX) begin
         eff_len = CNT_W'(WINDOW_MAX);
      end else begin
         eff_len = CNT_W'(win_len_ff);
      end
   end

   // Window memory: one write port, one registered read port
   logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
   logic                       mem_we;
   logic [PTR_W-1:0]           mem_waddr, mem_raddr;
   logic signed [SAMPLE_W-1:0] mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Sequencer state
   seq_state_type state_ff, state_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  k_ff, k_in;        // reads issued in current pass
   logic              rvld_ff, rvld_in;  // read data valid next cycle
   logic signed [23:0] sum_ff, sum_in;
   logic [47:0]       acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic              start_ff, start_in;
   logic              sq_start_ff, sq_start_in;
   logic [31:0]       var_ff, var_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [QUALITY_W-1:0] rsp_q_ff, rsp_q_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        sq_done;
   logic [15:0] sq_root;
   logic        sum_neg;
   logic [23:0] sum_mag;
   logic signed [SAMPLE_W:0] diff;
   logic [33:0] diff_sq;
   logic [PTR_W-1:0] k_ptr;

   manm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   manm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start_ff),
      .radicand (var_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign sum_neg = sum_ff[23];
   assign sum_mag = sum_neg ? 24'(-sum_ff) : 24'(sum_ff);
   assign diff    = (SAMPLE_W+1)'(mem_rdata_ff) - (SAMPLE_W+1)'(mean_ff);
   assign diff_sq = 34'(diff * diff);

   assign div_req.start    = start_ff;
   assign div_req.divisor  = LEN_W'(fill_ff);
   assign div_req.dividend = (state_ff == ST_DIV_VAR) ? acc_ff : 48'(sum_mag);

   // read address: newest first, k = 1 .. n back from the write pointer
   assign k_ptr     = PTR_W'(k_ff) + PTR_W'(1);
   assign mem_raddr = wptr_ff - k_ptr;
   assign mem_we    = (state_ff == ST_IDLE) && req.valid && req.ready;
   assign mem_waddr = wptr_ff;
   assign mem_wdata = req.sample;

   // the response register parts the two sides; only ST_OUT waits on it
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      wptr_in      = wptr_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      rvld_in      = 1'b0;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      start_in     = 1'b0;
      sq_start_in  = 1'b0;
      var_in       = var_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_q_in     = rsp_q_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               wptr_in  = wptr_ff + PTR_W'(1);
               fill_in  = (fill_ff < eff_len) ? fill_ff + CNT_W'(1) : eff_len;
               k_in     = '0;
               sum_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (rvld_ff) begin
               sum_in = sum_ff + 24'(mem_rdata_ff);
            end
            if (k_ff < fill_ff) begin
               k_in    = k_ff + CNT_W'(1);
               rvld_in = 1'b1;
            end else if (!rvld_ff) begin
               start_in = 1'b1;
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_rsp.done) begin
               mean_in  = sum_neg ? SAMPLE_W'(-div_rsp.quotient[SAMPLE_W-1:0])
                                  : SAMPLE_W'(div_rsp.quotient[SAMPLE_W-1:0]);
               k_in     = '0;
               acc_in   = '0;
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            if (rvld_ff) begin
               acc_in = acc_ff + 48'(diff_sq);
            end
            if (k_ff < fill_ff) begin
               k_in    = k_ff + CNT_W'(1);
               rvld_in = 1'b1;
            end else if (!rvld_ff) begin
               start_in = 1'b1;
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            if (div_rsp.done) begin
               var_in      = (div_rsp.quotient[47:32] != '0) ? 32'hFFFF_FFFF
                                                             : div_rsp.quotient[31:0];
               sq_start_in = 1'b1;
               state_in    = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // root holds until the next start, so quality is formed here
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_mean_in  = mean_ff;
               rsp_q_in     = (sq_root >= 16'd256) ? '0
                                                   : QUALITY_W'(17'd256 - 17'(sq_root));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         rvld_ff      <= 1'b0;
         start_ff     <= 1'b0;
         sq_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         rvld_ff      <= rvld_in;
         start_ff     <= start_in;
         sq_start_ff  <= sq_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      sum_ff      <= sum_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_q_ff    <= rsp_q_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.mean    = rsp_mean_ff;
   assign rsp.quality = rsp_q_ff;

endmodule

// ----- dv/tb_moving_average_noise_metric_unit.sv -----
// Testbench for the moving average noise metric unit: directed and random samples, checked.
module tb_moving_average_noise_metric_unit
   import manm_pkg::*;
;

   localparam int WIN_MAX     = 16;
   localparam int DRAIN_WAIT  = 300;     // comfortably above the worst-case latency
   localparam int CYCLE_LIMIT = 1500000;

   // One queued request: either a sample or a window length write.
   typedef struct {
      bit                 is_cfg;
      bit                 drain;   // hold off until all responses are back
      logic [LEN_W-1:0]   len;
      logic signed [15:0] sample;
   } stim_type;

   typedef struct {
      logic signed [15:0] mean;
      logic [8:0]         quality;
   } window_stats_type;

   logic clock;
   logic reset;
   logic             csr_write_enable;
   logic [LEN_W-1:0] csr_write_data;

   manm_req_if req ();
   manm_rsp_if rsp ();

   moving_average_noise_metric_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req.sink),
      .rsp              (rsp.source)
   );

   // Predictor state, a private copy of the block's window
   logic signed [15:0] ring_mem [WIN_MAX];
   int unsigned        held_count;
   int unsigned        ring_ptr;
   logic [LEN_W-1:0]   win_len;

   stim_type         pending_q [$];
   window_stats_type expected_stats_q [$];

   int  mismatches;
   int  samples_sent;
   int  stats_checked;
   int  cfg_writes;
   int  cycle_count;
   bit  stim_done;
   bit  quiet_tail;   // no idling in the final stretch

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] int_sqrt(input logic [31:0] val);
      logic [31:0] root;
      logic [31:0] bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > val) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (val >= root + bitv) begin
            val  = val - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Push one sample through the predictor and work out its mean and quality.
   function automatic window_stats_type predict_window_stats(input logic signed [15:0] smp);
      window_stats_type res;
      int unsigned   eff;
      int unsigned   slot;
      longint        total;
      longint        avg;
      longint        dev;
      longint unsigned sq_acc;
      longint unsigned spread;
      logic [31:0]   root;
      eff = (win_len == 0) ? 1 : (win_len > WIN_MAX) ? WIN_MAX : win_len;
      ring_mem[ring_ptr] = smp;
      ring_ptr = (ring_ptr + 1) % WIN_MAX;
      held_count = (held_count < eff) ? held_count + 1 : eff;
      total = 0;
      for (int k = 1; k <= held_count; k++) begin
         slot = (ring_ptr + WIN_MAX - k) % WIN_MAX;
         total += ring_mem[slot];
      end
      avg = total / longint'(held_count);   // truncates toward zero
      sq_acc = 0;
      for (int k = 1; k <= held_count; k++) begin
         slot = (ring_ptr + WIN_MAX - k) % WIN_MAX;
         dev = longint'(ring_mem[slot]) - avg;
         sq_acc += longint'(dev * dev);
      end
      spread = sq_acc / longint'(held_count);
      if (spread > 64'hFFFF_FFFF) spread = 64'hFFFF_FFFF;
      root = int_sqrt(spread[31:0]);
      res.mean    = avg[15:0];
      res.quality = (root >= 256) ? 9'd0 : 9'(256 - root);
      return res;
   endfunction

   function automatic void queue_sample(input logic signed [15:0] smp);
      stim_type s;
      s = '{is_cfg: 1'b0, drain: 1'b0, len: '0, sample: smp};
      pending_q = {pending_q, s};
   endfunction

   function automatic void queue_len(input logic [LEN_W-1:0] l);
      stim_type s;
      s = '{is_cfg: 1'b1, drain: 1'b1, len: l, sample: '0};
      pending_q = {pending_q, s};
   endfunction

   // Tight bursts keep samples close, so the spread is small and quality non-zero; else random.
   function automatic void queue_burst(input int cnt, input bit tight);
      int base;
      int span;
      base = $urandom_range(0, 65535) - 32768;
      span = tight ? $urandom_range(0, 300) : 65535;
      for (int i = 0; i < cnt; i++) begin
         if (tight)
            queue_sample(16'(base + $urandom_range(0, span) - span / 2));
         else
            queue_sample(16'($urandom));
      end
   endfunction

   // Stimulus plan
   initial begin
      stim_type hold;
      // Directed: default length 10, extremes while the window is still filling, then a constant run
      queue_sample(16'sh7FFF);
      queue_sample(-16'sh8000);
      queue_sample(16'sh0000);
      queue_sample(16'shFFFF);
      queue_sample(16'sh0001);
      for (int i = 0; i < 6; i++) queue_sample(16'sh0100);  // constant; extremes held, quality 0.0
      queue_len(5'd1);     // single sample window
      queue_sample(-16'sh8000);
      queue_sample(16'sh7FFF);
      queue_len(5'd0);     // zero treated as one
      queue_sample(16'sh1234);
      queue_sample(-16'sh0003);
      queue_len(5'd31);    // above the depth, clamped to 16
      for (int i = 0; i < 8; i++) queue_sample(16'(i * 13 - 40));
      queue_len(5'd16);
      queue_sample(16'sh5555);
      queue_sample(16'shAAAA);
      // Pause until everything is back, mid-run
      hold = '{is_cfg: 1'b0, drain: 1'b1, len: '0, sample: 16'sh0042};
      pending_q = {pending_q, hold};
      // Random part: phases of window lengths, mostly tight bursts
      for (int ph = 0; ph < 40; ph++) begin
         case (ph % 5)
            0: queue_len(5'd16);
            1: queue_len(5'd1);
            default: queue_len(5'($urandom_range(0, 31)));
         endcase
         queue_burst($urandom_range(30, 70), ($urandom_range(0, 3) != 0));
      end
      queue_len(5'd2);
      queue_burst(30, 1'b1);
   end

   // Driver: config writes and samples from the pending queue
   always @(posedge clock) begin
      static int idle_left = 0;
      if (reset) begin
         req.valid        <= 1'b0;
         req.sample       <= '0;
         csr_write_enable <= 1'b0;
         csr_write_data   <= '0;
         held_count = 0;
         ring_ptr   = 0;
         win_len    = WINDOW_RESET;
      end else begin
         static int quiet_left = 0;
         bit cfg_now;
         cfg_now = 1'b0;
         if (req.valid && req.ready) begin
            expected_stats_q = {expected_stats_q, predict_window_stats(req.sample)};
            samples_sent++;
         end
         if (!req.valid || req.ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req.valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
               req.valid <= 1'b0;
               stim_done = 1'b1;
            end else if (pending_q[0].drain &&
                         (expected_stats_q.size() != 0 || (req.valid && req.ready) ||
                          quiet_left < DRAIN_WAIT)) begin
               // Let the block settle completely before touching it
               req.valid <= 1'b0;
               quiet_left = (expected_stats_q.size() == 0 && !(req.valid && req.ready))
                            ? quiet_left + 1 : 0;
            end else if (pending_q[0].is_cfg) begin
               stim_type s;
               s = pending_q.pop_front();
               cfg_now = 1'b1;
               csr_write_data <= s.len;
               win_len = s.len;
               cfg_writes++;
               req.valid <= 1'b0;
               quiet_left = 0;
            end else begin
               stim_type s;
               s = pending_q.pop_front();
               quiet_left = 0;
               req.valid  <= 1'b1;
               req.sample <= s.sample;
               quiet_tail = (pending_q.size() < 40);
               if (!quiet_tail && $urandom_range(0, 9) == 0)
                  idle_left = $urandom_range(1, 17);
            end
         end
         csr_write_enable <= cfg_now;
      end
   end

   // Monitor: stalls the response side and checks each response
   always @(posedge clock) begin
      static int stall_left = 0;
      window_stats_type exp_stats;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_stats_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: mean %0d quality %0d", rsp.mean, rsp.quality);
            end else begin
               exp_stats = expected_stats_q.pop_front();
               stats_checked++;
               if (rsp.mean !== exp_stats.mean || rsp.quality !== exp_stats.quality) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d: mean exp %0d got %0d, quality exp %0d got %0d",
                              stats_checked, exp_stats.mean, rsp.mean,
                              exp_stats.quality, rsp.quality);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Reset, end of run and watchdog
   initial begin
      int settle;
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.sample       = '0;
      rsp.ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      settle = 0;
      while (settle < DRAIN_WAIT && cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
         if (stim_done && expected_stats_q.size() == 0 && !req.valid) settle++;
         else settle = 0;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
      end else begin
         $display("%0d samples, %0d responses checked, %0d window length writes",
                  samples_sent, stats_checked, cfg_writes);
         $display("%0d mismatches", mismatches);
         if (mismatches == 0 && expected_stats_q.size() == 0)
            $display("*** PASSED ***");
         else
            $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
